// ----- hdl/s4u_pkg.sv -----
// Shared types and mode codes for the stereo 4x upsampler.
package s4u_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 2;
    localparam int UP_STEPS = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [MODE_W-1:0]          mode_t;
    typedef logic signed [17:0]         comb_t;
    typedef logic signed [18:0]         diff_t;
    typedef logic [31:0]                integ_t;
    typedef logic [1:0]                 phase_t;

    localparam mode_t MODE_PASS   = 2'd0;
    localparam mode_t MODE_LINEAR = 2'd1;
    localparam mode_t MODE_CIC    = 2'd2;

endpackage

// ----- hdl/s4u_sample_if.sv -----
// Input channel: one stereo sample word with per-channel present flags.
interface s4u_sample_if
    import s4u_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_left;
    sample_t sample_right;
    logic    left_present;
    logic    right_present;

    modport source (
        output valid, sample_left, sample_right, left_present, right_present,
        input  ready
    );
    modport sink (
        input  valid, sample_left, sample_right, left_present, right_present,
        output ready
    );
endinterface

// ----- hdl/s4u_result_if.sv -----
// Output channel: one upsampled stereo word with an end-of-group flag.
interface s4u_result_if
    import s4u_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t out_left;
    sample_t out_right;
    logic    last;

    modport source (
        output valid, out_left, out_right, last,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_right, last,
        output ready
    );
endinterface

// ----- hdl/s4u_cfg_if.sv -----
// Configuration write channel carrying the interpolation mode.
interface s4u_cfg_if
    import s4u_pkg::*;
();
    logic  valid;
    logic  ready;
    mode_t data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ----- hdl/stereo_4x_upsampler_unit.sv -----
// Stereo 4x upsampler: passthrough, linear and 3-stage CIC interpolation.
//
// Each accepted stereo word is first held in an input register, then loaded
// into the issue stage, where the comb section and the linear midpoints are
// worked out in one pass; the issue stage then sends one output word per
// cycle through the output register while the output side keeps up. In
// linear and CIC modes a word yields four output words and the next word is
// loaded as the fourth is issued; in passthrough mode (or mode code 3) a word
// yields one output word and one word is taken every cycle while the output
// side keeps up. The output register is the pacing point: one word leaves per
// cycle unless results.ready stalls it. The CIC integrators advance once per
// issued word, so the three integrator adds sit in that issue cycle. Each word
// passes the input register, issue stage and output register. An absent
// channel outputs zeros and leaves its filter state untouched. Mode writes are
// taken at any time and apply to words loaded into the issue stage afterwards.
module stereo_4x_upsampler_unit
    import s4u_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    s4u_sample_if.sink    samples,
    s4u_result_if.source  results,
    s4u_cfg_if.sink       cfg
);

    typedef enum logic [1:0] {KIND_PASS, KIND_LIN, KIND_CIC} kind_t;

    // configuration
    mode_t   mode_reg, mode_next;

    // input register
    logic    in_valid_reg, in_valid_next;
    sample_t in_sample_reg [2];
    sample_t in_sample_next [2];
    logic    in_present_reg [2];
    logic    in_present_next [2];

    // issue stage
    logic    busy_reg, busy_next;
    phase_t  phase_reg, phase_next;
    kind_t   kind_reg, kind_next;
    logic    present_reg [2];
    logic    present_next [2];
    sample_t lin_reg [2][UP_STEPS];
    sample_t lin_next [2][UP_STEPS];
    diff_t   d2_reg [2];
    diff_t   d2_next [2];

    // filter state
    sample_t prev_reg [2];
    sample_t prev_next [2];
    comb_t   comb0_reg [2];
    comb_t   comb0_next [2];
    comb_t   comb1_reg [2];
    comb_t   comb1_next [2];
    integ_t  integ0_reg [2];
    integ_t  integ0_next [2];
    integ_t  integ1_reg [2];
    integ_t  integ1_next [2];
    integ_t  integ2_reg [2];
    integ_t  integ2_next [2];

    // output register
    logic    out_valid_reg, out_valid_next;
    sample_t out_data_reg [2];
    sample_t out_data_next [2];
    logic    out_last_reg, out_last_next;

    // per-channel datapath values
    logic signed [16:0] mid_sum [2];
    logic signed [16:0] lo_sum [2];
    logic signed [16:0] hi_sum [2];
    sample_t            mid_val [2];
    logic signed [16:0] d0_val [2];
    comb_t              d1_val [2];
    diff_t              d2_val [2];
    integ_t             feed_val [2];
    integ_t             s0_val [2];
    integ_t             s1_val [2];
    integ_t             s2_val [2];

    kind_t   load_kind;
    logic    step;
    logic    step_last;
    logic    load;
    logic    in_ready;

    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            // linear: midpoint, then quarter points, all floor halves
            mid_sum[ch] = prev_reg[ch] + in_sample_reg[ch];
            mid_val[ch] = mid_sum[ch][16:1];
            lo_sum[ch]  = prev_reg[ch] + mid_val[ch];
            hi_sum[ch]  = mid_val[ch] + in_sample_reg[ch];
            // comb section at the input rate
            d0_val[ch]  = {in_sample_reg[ch][15], in_sample_reg[ch]}
                          - {prev_reg[ch][15], prev_reg[ch]};
            d1_val[ch]  = {d0_val[ch][16], d0_val[ch]} - comb0_reg[ch];
            d2_val[ch]  = {d1_val[ch][17], d1_val[ch]}
                          - {comb1_reg[ch][17], comb1_reg[ch]};
            // integrators: comb output enters on the first phase, zeros after
            feed_val[ch] = (phase_reg == '0) ? {{13{d2_reg[ch][18]}}, d2_reg[ch]}
                                             : '0;
            s0_val[ch]  = integ0_reg[ch] + feed_val[ch];
            s1_val[ch]  = integ1_reg[ch] + s0_val[ch];
            s2_val[ch]  = integ2_reg[ch] + s1_val[ch];
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_LINEAR: load_kind = KIND_LIN;
            MODE_CIC:    load_kind = KIND_CIC;
            default:     load_kind = KIND_PASS;
        endcase

        step      = busy_reg && (!out_valid_reg || results.ready);
        step_last = (kind_reg == KIND_PASS) || (phase_reg == phase_t'(UP_STEPS - 1));
        load      = in_valid_reg && (!busy_reg || (step && step_last));
        in_ready  = !in_valid_reg || load;

        mode_next      = mode_reg;
        in_valid_next  = in_valid_reg;
        in_sample_next = in_sample_reg;
        in_present_next = in_present_reg;
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        present_next   = present_reg;
        lin_next       = lin_reg;
        d2_next        = d2_reg;
        prev_next      = prev_reg;
        comb0_next     = comb0_reg;
        comb1_next     = comb1_reg;
        integ0_next    = integ0_reg;
        integ1_next    = integ1_reg;
        integ2_next    = integ2_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cfg.valid)
        begin
            mode_next = cfg.data;
        end

        // input register: hold until the issue stage takes the word
        if (samples.valid && in_ready)
        begin
            in_valid_next      = 1'b1;
            in_sample_next[0]  = samples.sample_left;
            in_sample_next[1]  = samples.sample_right;
            in_present_next[0] = samples.left_present;
            in_present_next[1] = samples.right_present;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end

        // output register and integrator advance
        if (step)
        begin
            out_valid_next = 1'b1;
            out_last_next  = step_last;
            for (int ch = 0; ch < 2; ch++)
            begin
                if (!present_reg[ch])
                begin
                    out_data_next[ch] = '0;
                end
                else
                begin
                    case (kind_reg)
                        KIND_LIN:
                        begin
                            out_data_next[ch] = lin_reg[ch][phase_reg];
                        end
                        KIND_CIC:
                        begin
                            out_data_next[ch] = s2_val[ch][19:4];
                            integ0_next[ch]   = s0_val[ch];
                            integ1_next[ch]   = s1_val[ch];
                            integ2_next[ch]   = s2_val[ch];
                        end
                        default:
                        begin
                            out_data_next[ch] = lin_reg[ch][UP_STEPS-1];
                        end
                    endcase
                end
            end
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        // issue stage: load a new word or advance the phase
        if (load)
        begin
            busy_next  = 1'b1;
            phase_next = '0;
            kind_next  = load_kind;
            for (int ch = 0; ch < 2; ch++)
            begin
                present_next[ch] = in_present_reg[ch];
                lin_next[ch][0]  = lo_sum[ch][16:1];
                lin_next[ch][1]  = mid_val[ch];
                lin_next[ch][2]  = hi_sum[ch][16:1];
                lin_next[ch][3]  = in_sample_reg[ch];
                d2_next[ch]      = d2_val[ch];
                if (in_present_reg[ch] && (load_kind != KIND_PASS))
                begin
                    prev_next[ch] = in_sample_reg[ch];
                    if (load_kind == KIND_CIC)
                    begin
                        comb0_next[ch] = {d0_val[ch][16], d0_val[ch]};
                        comb1_next[ch] = d1_val[ch];
                    end
                end
            end
        end
        else if (step)
        begin
            if (step_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LINEAR;
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            kind_reg      <= KIND_PASS;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < 2; ch++)
            begin
                prev_reg[ch]   <= '0;
                comb0_reg[ch]  <= '0;
                comb1_reg[ch]  <= '0;
                integ0_reg[ch] <= '0;
                integ1_reg[ch] <= '0;
                integ2_reg[ch] <= '0;
            end
        end
        else
        begin
            mode_reg      <= mode_next;
            in_valid_reg  <= in_valid_next;
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            comb0_reg     <= comb0_next;
            comb1_reg     <= comb1_next;
            integ0_reg    <= integ0_next;
            integ1_reg    <= integ1_next;
            integ2_reg    <= integ2_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_sample_reg  <= in_sample_next;
        in_present_reg <= in_present_next;
        present_reg    <= present_next;
        lin_reg        <= lin_next;
        d2_reg         <= d2_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign samples.ready     = in_ready;
    assign cfg.ready         = 1'b1;
    assign results.valid     = out_valid_reg;
    assign results.out_left  = out_data_reg[0];
    assign results.out_right = out_data_reg[1];
    assign results.last      = out_last_reg;

endmodule
